>>> rtl/tsoqa_pkg.sv
// Shared types and constants of the temperature sensor averaging unit.
package tsoqa_pkg;

    // Input command codes
    localparam logic CMD_OFFSET = 1'b0;
    localparam logic CMD_TEMP   = 1'b1;

    // Field widths
    localparam int READ_W   = 12;
    localparam int RAW_W    = 14;
    localparam int BIAS_W   = 15;
    localparam int TENTHS_W = 16;
    localparam int AVG_W    = 20;
    localparam int SUM_W    = 22;

    // Quadratic datapath widths
    localparam int SQ_W  = 28;
    localparam int LIN_W = 29;
    localparam int Q_W   = 30;
    localparam int MAG_W = 28;
    localparam int QE_W  = 15;
    localparam int BK_W  = 29;

    // Averaging datapath widths
    localparam int S10_W = 26;
    localparam int N_W   = 24;

    localparam logic signed [BIAS_W-1:0] BIAS_RESET = 15'sd5000;

    // tenths = (-x*x + COEF_B*x + COEF_C + bias) / DIVISOR
    localparam logic signed [LIN_W-1:0] COEF_B  = 29'sd26100;
    localparam logic signed [Q_W-1:0]   COEF_C  = 30'sd6100000;
    localparam logic [13:0]             DIVISOR = 14'd10000;

    // floor(2^40 / 10000); the estimate is low by at most one
    localparam int                 RECIP_SHIFT = 40;
    localparam logic [26:0]        RECIP       = 27'd109951162;

    // Shift paired with the ceiling reciprocal of the averaging length
    localparam int AVG_SHIFT = 31;

    // Per-sensor conversion state
    typedef struct packed {
        logic signed [READ_W-1:0] offset;
        logic signed [RAW_W-1:0]  raw;
        logic                     ofail;
    } sens_a_t;

endpackage

>>> rtl/temp_sensor_offset_quadratic_average_unit.sv
// Top level of the per-sensor temperature conversion and averaging unit.
//
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  tdata: sensor, high_byte, low_register;
//                                    tuser: command, timed_out
//  m_*       out  m_tvalid/m_tready  tdata: tenths_degrees, average_hundredths; tlast: window_done;
//                                    tuser: failed
//  cfg_*     in   cfg_wr_en          round_bias
//
// One item per cycle in any sensor mix while m_tready does not stall the pipeline; a result passes
// through the ten-register pipeline (state read, two multiplies of the divide-by-10000, the
// accumulate and the divide by the window length) and is offered once it reaches the last stage.
// Offset items end after the state stage.
// Reset clears all sensor state to zero (entries read as zero until written), round_bias to 5000.
// A stalled m_tready fills the empty stages first; s_tready drops only when the first stage is held.
module temp_sensor_offset_quadratic_average_unit #(
    parameter int SENSOR_COUNT   = 4,
    parameter int AVERAGE_LENGTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // sensor[1:0], high_byte[9:2], low_register[17:10], zero pad
    input  logic [1:0]  s_tuser,   // command[0], timed_out[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // tenths_degrees[15:0], average_hundredths[35:16], zero pad
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // failed[0]
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data
);

    localparam int AW    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CW    = $clog2(AVERAGE_LENGTH + 1);
    localparam int B_W   = tsoqa_pkg::SUM_W + CW;
    localparam int TAG_W = AW + 1;
    localparam int NST   = 10;
    localparam logic [31:0] AVG_RECIP =
        32'(((64'd1 << tsoqa_pkg::AVG_SHIFT) + 64'(AVERAGE_LENGTH) - 64'd1)
            / 64'(AVERAGE_LENGTH));

    logic signed [tsoqa_pkg::BIAS_W-1:0] round_bias_reg;

    logic [NST:1] v_reg, v_next;
    logic [NST:1] free;
    logic         leave1;

    // stage 1: reading and its sensor state
    logic                                p1_cmd_reg, p1_tmo_reg;
    logic [AW-1:0]                       p1_addr_reg;
    logic signed [tsoqa_pkg::READ_W-1:0] p1_rd_reg;
    logic [AW-1:0]                       in_addr;
    logic                                in_range;
    tsoqa_pkg::sens_a_t                  a_rdata, a_wdata;
    logic [AW-1:0]                       a_raddr;
    logic                                p1_fail;

    // conversion pipeline
    logic [TAG_W-1:0]                      tag_c4, tag_c5;
    logic signed [tsoqa_pkg::TENTHS_W-1:0] c5_tenths;

    // stage 6 accumulate
    logic [B_W-1:0]                     b_rdata, b_wdata;
    logic [AW-1:0]                      b_raddr;
    logic signed [tsoqa_pkg::SUM_W-1:0] sum_old, sum_new;
    logic [CW-1:0]                      cnt_old, cnt_new;
    logic                               win_end;

    // stages 7..9 average
    logic signed [tsoqa_pkg::TENTHS_W-1:0] t7_reg, t8_reg, t9_reg;
    logic                                  f7_reg, f8_reg, f9_reg;
    logic                                  d7_reg, d8_reg, d9_reg;
    logic signed [tsoqa_pkg::SUM_W-1:0]    sum7_reg;
    logic signed [tsoqa_pkg::S10_W-1:0]    s10;
    logic [tsoqa_pkg::N_W-1:0]             n8_reg, n8_next;
    logic                                  neg8_reg, neg9_reg;
    logic [tsoqa_pkg::N_W+31:0]            avg_prod;
    logic [tsoqa_pkg::N_W-1:0]             q9_reg;
    logic signed [tsoqa_pkg::AVG_W-1:0]    avg_next;

    // output register
    logic signed [tsoqa_pkg::TENTHS_W-1:0] out_tenths_reg;
    logic signed [tsoqa_pkg::AVG_W-1:0]    out_avg_reg;
    logic                                  out_done_reg, out_fail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_bias_reg <= tsoqa_pkg::BIAS_RESET;
        end
        else if (cfg_wr_en)
        begin
            round_bias_reg <= $signed(cfg_wr_data);
        end
    end

    // Flow control: a stage may load when empty or when its item moves on
    always_comb
    begin
        free[NST] = !v_reg[NST] || m_tready;
        for (int k = NST - 1; k >= 2; k--)
        begin
            free[k] = !v_reg[k] || free[k+1];
        end
        // offset items retire from stage 1 without a successor
        free[1] = !v_reg[1] || (p1_cmd_reg == tsoqa_pkg::CMD_OFFSET) || free[2];
        leave1  = v_reg[1] && free[1];

        v_next = v_reg;
        if (free[1])
        begin
            v_next[1] = s_tvalid && in_range;
        end
        if (free[2])
        begin
            v_next[2] = v_reg[1] && (p1_cmd_reg == tsoqa_pkg::CMD_TEMP);
        end
        for (int k = 3; k <= NST; k++)
        begin
            if (free[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = free[1];
    assign in_addr  = AW'(s_tdata[1:0]);
    assign in_range = int'(s_tdata[1:0]) < SENSOR_COUNT;

    always_ff @(posedge clk)
    begin
        if (free[1])
        begin
            p1_cmd_reg  <= s_tuser[0];
            p1_tmo_reg  <= s_tuser[1];
            p1_addr_reg <= in_addr;
            p1_rd_reg   <= $signed({s_tdata[9:2], s_tdata[13:10]});
        end
    end

    // Stage 1: update offset / raw state
    assign a_raddr = free[1] ? in_addr : p1_addr_reg;

    always_comb
    begin
        p1_fail = p1_tmo_reg || a_rdata.ofail;
        a_wdata = a_rdata;
        if (p1_cmd_reg == tsoqa_pkg::CMD_OFFSET)
        begin
            a_wdata.offset = p1_tmo_reg ? '0 : p1_rd_reg;
            a_wdata.ofail  = p1_tmo_reg;
        end
        else if (!p1_fail)
        begin
            a_wdata.raw = tsoqa_pkg::RAW_W'(p1_rd_reg) - tsoqa_pkg::RAW_W'(a_rdata.offset);
        end
    end

    tsoqa_ram #(
        .WIDTH ($bits(tsoqa_pkg::sens_a_t)),
        .DEPTH (SENSOR_COUNT),
        .AW    (AW)
    ) u_state_a (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (leave1),
        .waddr (p1_addr_reg),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    tsoqa_conv #(
        .TAG_W (TAG_W)
    ) u_conv (
        .clk    (clk),
        .ld     (free[6:2]),
        .x      (a_wdata.raw),
        .bias   (round_bias_reg),
        .tag    ({p1_addr_reg, p1_fail}),
        .tag_c4 (tag_c4),
        .tag_c5 (tag_c5),
        .tenths (c5_tenths)
    );

    // Stage 6: window sum and count
    assign b_raddr = free[6] ? tag_c4[TAG_W-1:1] : tag_c5[TAG_W-1:1];

    always_comb
    begin
        sum_old = $signed(b_rdata[B_W-1:CW]);
        cnt_old = b_rdata[CW-1:0];
        sum_new = sum_old + tsoqa_pkg::SUM_W'(c5_tenths);
        cnt_new = cnt_old + CW'(1);
        win_end = cnt_new >= CW'(AVERAGE_LENGTH);
        b_wdata = win_end ? '0 : {sum_new, cnt_new};
    end

    tsoqa_ram #(
        .WIDTH (B_W),
        .DEPTH (SENSOR_COUNT),
        .AW    (AW)
    ) u_state_b (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (v_reg[6] && free[7]),
        .waddr (tag_c5[TAG_W-1:1]),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Average: sum * 10 / AVERAGE_LENGTH, truncated toward zero
    always_comb
    begin
        s10      = (tsoqa_pkg::S10_W'(sum7_reg) <<< 3) + (tsoqa_pkg::S10_W'(sum7_reg) <<< 1);
        n8_next  = s10[tsoqa_pkg::S10_W-1] ? tsoqa_pkg::N_W'(-s10) : tsoqa_pkg::N_W'(s10);
        avg_prod = (tsoqa_pkg::N_W+32)'(n8_reg) * (tsoqa_pkg::N_W+32)'(AVG_RECIP);
        if (!d9_reg)
        begin
            avg_next = '0;
        end
        else if (neg9_reg)
        begin
            avg_next = -tsoqa_pkg::AVG_W'(q9_reg);
        end
        else
        begin
            avg_next = tsoqa_pkg::AVG_W'(q9_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (free[7])
        begin
            t7_reg   <= c5_tenths;
            f7_reg   <= tag_c5[0];
            d7_reg   <= win_end;
            sum7_reg <= sum_new;
        end
        if (free[8])
        begin
            t8_reg   <= t7_reg;
            f8_reg   <= f7_reg;
            d8_reg   <= d7_reg;
            n8_reg   <= n8_next;
            neg8_reg <= s10[tsoqa_pkg::S10_W-1];
        end
        if (free[9])
        begin
            t9_reg   <= t8_reg;
            f9_reg   <= f8_reg;
            d9_reg   <= d8_reg;
            neg9_reg <= neg8_reg;
            q9_reg   <= avg_prod[tsoqa_pkg::AVG_SHIFT+tsoqa_pkg::N_W-1:tsoqa_pkg::AVG_SHIFT];
        end
        if (free[10])
        begin
            out_tenths_reg <= t9_reg;
            out_avg_reg    <= avg_next;
            out_done_reg   <= d9_reg;
            out_fail_reg   <= f9_reg;
        end
    end

    assign m_tvalid = v_reg[NST];
    assign m_tdata  = {4'b0000, out_avg_reg, out_tenths_reg};
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_fail_reg;

endmodule

>>> rtl/tsoqa_ram.sv
// Small state memory: one write port, one registered write-first read port, reset-cleared entries.
module tsoqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A write to the address being read is passed straight through
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else if (vld_reg[raddr])
        begin
            rdata_reg <= mem[raddr];
        end
        else
        begin
            rdata_reg <= '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tsoqa_conv.sv
// Five-stage conversion of a raw reading to tenths of a degree.
module tsoqa_conv #(
    parameter int TAG_W = 3
) (
    input  logic                                   clk,
    input  logic [4:0]                             ld,
    input  logic signed [tsoqa_pkg::RAW_W-1:0]     x,
    input  logic signed [tsoqa_pkg::BIAS_W-1:0]    bias,
    input  logic [TAG_W-1:0]                       tag,
    output logic [TAG_W-1:0]                       tag_c4,
    output logic [TAG_W-1:0]                       tag_c5,
    output logic signed [tsoqa_pkg::TENTHS_W-1:0]  tenths
);

    // stage 1: products
    logic signed [tsoqa_pkg::SQ_W-1:0]  sq_reg, sq_next;
    logic signed [tsoqa_pkg::LIN_W-1:0] lin_reg, lin_next;
    logic [TAG_W-1:0]                   tag1_reg;
    // stage 2: magnitude of the numerator
    logic signed [tsoqa_pkg::Q_W-1:0]   q_sum;
    logic [tsoqa_pkg::MAG_W-1:0]        mag2_reg, mag2_next;
    logic                               neg2_reg;
    logic [TAG_W-1:0]                   tag2_reg;
    // stage 3: reciprocal estimate
    logic [tsoqa_pkg::MAG_W+26:0]       est_prod;
    logic [tsoqa_pkg::QE_W-1:0]         qe3_reg;
    logic [tsoqa_pkg::MAG_W-1:0]        mag3_reg;
    logic                               neg3_reg;
    logic [TAG_W-1:0]                   tag3_reg;
    // stage 4: back product
    logic [tsoqa_pkg::BK_W-1:0]         bk4_reg, bk4_next;
    logic [tsoqa_pkg::QE_W-1:0]         qe4_reg;
    logic [tsoqa_pkg::MAG_W-1:0]        mag4_reg;
    logic                               neg4_reg;
    logic [TAG_W-1:0]                   tag4_reg;
    // stage 5: corrected, signed quotient
    logic [tsoqa_pkg::BK_W-1:0]         rem;
    logic [tsoqa_pkg::QE_W-1:0]         qf;
    logic signed [tsoqa_pkg::TENTHS_W-1:0] tenths5_reg, tenths5_next;
    logic [TAG_W-1:0]                   tag5_reg;

    always_comb
    begin
        sq_next  = tsoqa_pkg::SQ_W'(x) * tsoqa_pkg::SQ_W'(x);
        lin_next = tsoqa_pkg::LIN_W'(x) * tsoqa_pkg::COEF_B;

        // leading coefficient is -1
        q_sum = tsoqa_pkg::Q_W'(lin_reg) - tsoqa_pkg::Q_W'(sq_reg) + tsoqa_pkg::COEF_C
              + tsoqa_pkg::Q_W'(bias);
        mag2_next = q_sum[tsoqa_pkg::Q_W-1] ? tsoqa_pkg::MAG_W'(-q_sum)
                                            : tsoqa_pkg::MAG_W'(q_sum);

        est_prod = (tsoqa_pkg::MAG_W+27)'(mag2_reg) * (tsoqa_pkg::MAG_W+27)'(tsoqa_pkg::RECIP);

        bk4_next = tsoqa_pkg::BK_W'(qe3_reg) * tsoqa_pkg::BK_W'(tsoqa_pkg::DIVISOR);

        rem = tsoqa_pkg::BK_W'(mag4_reg) - bk4_reg;
        qf  = qe4_reg + ((rem >= tsoqa_pkg::BK_W'(tsoqa_pkg::DIVISOR)) ? 15'd1 : 15'd0);
        tenths5_next = neg4_reg ? -tsoqa_pkg::TENTHS_W'(qf) : tsoqa_pkg::TENTHS_W'(qf);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            sq_reg   <= sq_next;
            lin_reg  <= lin_next;
            tag1_reg <= tag;
        end
        if (ld[1])
        begin
            mag2_reg <= mag2_next;
            neg2_reg <= q_sum[tsoqa_pkg::Q_W-1];
            tag2_reg <= tag1_reg;
        end
        if (ld[2])
        begin
            qe3_reg  <= est_prod[tsoqa_pkg::RECIP_SHIFT+tsoqa_pkg::QE_W-1:tsoqa_pkg::RECIP_SHIFT];
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            tag3_reg <= tag2_reg;
        end
        if (ld[3])
        begin
            bk4_reg  <= bk4_next;
            qe4_reg  <= qe3_reg;
            mag4_reg <= mag3_reg;
            neg4_reg <= neg3_reg;
            tag4_reg <= tag3_reg;
        end
        if (ld[4])
        begin
            tenths5_reg <= tenths5_next;
            tag5_reg    <= tag4_reg;
        end
    end

    assign tag_c4 = tag4_reg;
    assign tag_c5 = tag5_reg;
    assign tenths = tenths5_reg;

endmodule

>>> rtl/tsoqa_checker.sv
// Port-level checks for the temperature averaging unit, bound to the top level.
module tsoqa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser,
    input logic        cfg_wr_en,
    input logic [14:0] cfg_wr_data
);

    // held result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // average only reported on the last sample of a window
    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[35:16] == 20'd0)
        else $error("average nonzero outside window end");

    // converted value stays inside what a 13-bit raw difference can give
    a_tenths_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) >= -16'sd12000)
                     && ($signed(m_tdata[15:0]) <= 16'sd12000))
        else $error("tenths out of range");

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind temp_sensor_offset_quadratic_average_unit tsoqa_checker u_checker (.*);

>>> verif/tsoqa_conversion_check.sv
// Result checker for the temperature averaging unit: predicts each result and compares it.
`timescale 1ns / 1ps

module tsoqa_conversion_check
    import tsoqa_pkg::*;
#(
    parameter int SENSOR_COUNT   = 4,
    parameter int AVERAGE_LENGTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    output int          mismatches,
    output int          pending,
    output int          results_seen,
    output int          windows_seen,
    output int          flagged_seen
);

    typedef struct packed {
        logic signed [TENTHS_W-1:0] tenths;
        logic signed [AVG_W-1:0]    avg;
        logic                       done;
        logic                       failed;
    } reading_result_t;

    reading_result_t expected_readings[$];

    logic signed [BIAS_W-1:0] round_bias;
    logic signed [READ_W-1:0] sensor_offset [SENSOR_COUNT];
    logic signed [RAW_W-1:0]  sensor_raw    [SENSOR_COUNT];
    logic                     offset_bad    [SENSOR_COUNT];
    logic signed [SUM_W-1:0]  window_sum    [SENSOR_COUNT];
    int                       window_fill   [SENSOR_COUNT];

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    function automatic logic signed [TENTHS_W-1:0] quad_tenths(
        input logic signed [RAW_W-1:0]  x,
        input logic signed [BIAS_W-1:0] b
    );
        longint xv;
        longint q;
        xv = x;
        q = -(xv * xv) + longint'(COEF_B) * xv + longint'(COEF_C) + longint'(b);
        return TENTHS_W'(q / longint'(DIVISOR));
    endfunction

    task automatic convert_reading(
        input logic       cmd,
        input logic [1:0] sensor,
        input logic [7:0] hi,
        input logic [7:0] lo,
        input logic       tmo
    );
        logic signed [READ_W-1:0] rd;
        reading_result_t res;
        longint scaled;
        rd = {hi, lo[3:0]};
        if (sensor >= SENSOR_COUNT)
            return;
        if (cmd == CMD_OFFSET)
        begin
            // offset is cleared first; a timed-out reading leaves it at zero
            sensor_offset[sensor] = '0;
            offset_bad[sensor] = tmo;
            if (!tmo)
                sensor_offset[sensor] = rd;
            return;
        end
        res.failed = tmo || offset_bad[sensor];
        if (!res.failed)
            sensor_raw[sensor] = rd - sensor_offset[sensor];
        res.tenths = quad_tenths(sensor_raw[sensor], round_bias);
        window_sum[sensor] = window_sum[sensor] + res.tenths;
        window_fill[sensor]++;
        res.avg = '0;
        res.done = 1'b0;
        if (window_fill[sensor] >= AVERAGE_LENGTH)
        begin
            scaled = longint'(window_sum[sensor]) * 10;
            res.avg = AVG_W'(scaled / AVERAGE_LENGTH);
            res.done = 1'b1;
            window_sum[sensor] = '0;
            window_fill[sensor] = 0;
        end
        expected_readings.push_back(res);
    endtask

    task automatic check_result();
        reading_result_t want;
        results_seen++;
        windows_seen += int'(m_tlast);
        flagged_seen += int'(m_tuser[0]);
        if (expected_readings.size() == 0)
        begin
            report_mismatch($sformatf("result with no reading waiting, tenths %0d",
                                      $signed(m_tdata[15:0])));
            return;
        end
        want = expected_readings.pop_front();
        if ($signed(m_tdata[15:0]) != want.tenths)
            report_mismatch($sformatf("tenths_degrees got %0d, expected %0d",
                                      $signed(m_tdata[15:0]), want.tenths));
        if ($signed(m_tdata[35:16]) != want.avg)
            report_mismatch($sformatf("average_hundredths got %0d, expected %0d",
                                      $signed(m_tdata[35:16]), want.avg));
        if (m_tlast != want.done)
            report_mismatch($sformatf("window_done got %0b, expected %0b",
                                      m_tlast, want.done));
        if (m_tuser[0] != want.failed)
            report_mismatch($sformatf("failed got %0b, expected %0b",
                                      m_tuser[0], want.failed));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_bias = BIAS_RESET;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                sensor_offset[i] = '0;
                sensor_raw[i] = '0;
                offset_bad[i] = 1'b0;
                window_sum[i] = '0;
                window_fill[i] = 0;
            end
            expected_readings.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_wr_en)
                round_bias = cfg_wr_data;
            if (s_tvalid && s_tready)
                convert_reading(s_tuser[0], s_tdata[1:0], s_tdata[9:2], s_tdata[17:10],
                                s_tuser[1]);
            pending = expected_readings.size();
        end
    end

endmodule

>>> verif/temp_sensor_offset_quadratic_average_unit_tb.sv
// Testbench top for the temperature averaging unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module temp_sensor_offset_quadratic_average_unit_tb;
    import tsoqa_pkg::*;

    localparam int SENSORS    = 4;
    localparam int WINDOW_LEN = 8;
    localparam int DRAIN_WAIT = 12;   // pipeline depth plus margin
    localparam int PHASE_LEN  = 230;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // sensor[1:0], high_byte[9:2], low_register[17:10], zero pad
    logic [1:0]  s_tuser;   // command[0], timed_out[1]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // tenths_degrees[15:0], average_hundredths[35:16], zero pad
    logic        m_tlast;
    logic [0:0]  m_tuser;   // failed[0]
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;

    int mismatches;
    int pending;
    int results_seen;
    int windows_seen;
    int flagged_seen;

    int items_sent;
    int bias_settings;
    bit sender_steady;
    bit sink_steady;
    bit hold_request;
    int bias_plan[6];

    temp_sensor_offset_quadratic_average_unit #(
        .SENSOR_COUNT  (SENSORS),
        .AVERAGE_LENGTH(WINDOW_LEN)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    tsoqa_conversion_check #(
        .SENSOR_COUNT  (SENSORS),
        .AVERAGE_LENGTH(WINDOW_LEN)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .results_seen(results_seen),
        .windows_seen(windows_seen),
        .flagged_seen(flagged_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver side: random stalls plus an occasional long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                stall_left = 400;
                hold_request = 1'b0;
            end
            if (stall_left == 0 && !sink_steady && $urandom_range(99) < 15)
                stall_left = gap_len();
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic send_reading(
        input logic       cmd,
        input logic [1:0] sensor,
        input logic [7:0] hi,
        input logic [7:0] lo,
        input logic       tmo
    );
        int gap;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = {6'b0, lo, hi, sensor};
        s_tuser = {tmo, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        gap = (sender_steady || $urandom_range(99) < 60) ? 0 : gap_len();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    task automatic send_random_reading();
        logic       cmd;
        logic [7:0] hi;
        cmd = ($urandom_range(99) < 15) ? CMD_OFFSET : CMD_TEMP;
        case ($urandom_range(7))
            0: hi = 8'h00;
            1: hi = 8'h7f;
            2: hi = 8'h80;
            3: hi = 8'hff;
            default: hi = 8'($urandom_range(255));
        endcase
        send_reading(cmd, 2'($urandom_range(3)), hi, 8'($urandom_range(255)),
                     $urandom_range(99) < 8);
    endtask

    // sender waits for every expected result, then lets the pipeline empty
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_bias(input int value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = 15'(value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        bias_settings++;
    endtask

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        sender_steady = 1'b0;
        sink_steady = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        bias_settings = 1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset bias
        send_reading(CMD_TEMP,   2'd0, 8'h00, 8'h00, 1'b0);  // before any offset
        send_reading(CMD_TEMP,   2'd0, 8'h7f, 8'hff, 1'b0);
        send_reading(CMD_TEMP,   2'd0, 8'h80, 8'h00, 1'b0);
        send_reading(CMD_OFFSET, 2'd1, 8'hff, 8'h0f, 1'b0);
        send_reading(CMD_TEMP,   2'd1, 8'h7f, 8'hff, 1'b0);
        send_reading(CMD_OFFSET, 2'd2, 8'h80, 8'hf0, 1'b0);  // upper low bits ignored
        send_reading(CMD_TEMP,   2'd2, 8'h7f, 8'hff, 1'b0);  // largest positive raw
        send_reading(CMD_OFFSET, 2'd3, 8'h7f, 8'hff, 1'b0);
        send_reading(CMD_TEMP,   2'd3, 8'h80, 8'h00, 1'b0);  // largest negative raw
        send_reading(CMD_OFFSET, 2'd0, 8'h12, 8'h34, 1'b1);  // offset times out
        send_reading(CMD_TEMP,   2'd0, 8'h55, 8'ha5, 1'b0);
        send_reading(CMD_TEMP,   2'd0, 8'h55, 8'ha5, 1'b1);
        send_reading(CMD_OFFSET, 2'd0, 8'h00, 8'h03, 1'b0);  // good offset clears flag
        send_reading(CMD_TEMP,   2'd0, 8'h01, 8'h07, 1'b0);
        send_reading(CMD_TEMP,   2'd1, 8'h44, 8'h44, 1'b1);  // raw value reused
        send_reading(CMD_TEMP,   2'd0, 8'hff, 8'hff, 1'b0);
        send_reading(CMD_TEMP,   2'd0, 8'h3c, 8'h5a, 1'b0);  // closes sensor 0 window
        send_reading(CMD_TEMP,   2'd1, 8'h00, 8'h00, 1'b0);
        send_reading(CMD_TEMP,   2'd2, 8'haa, 8'h55, 1'b1);
        settle();

        bias_plan = '{-9999, 9999, 0, 0, 0, 5000};
        bias_plan[3] = int'($urandom_range(19998)) - 9999;
        bias_plan[4] = int'($urandom_range(19998)) - 9999;
        foreach (bias_plan[i])
        begin
            write_bias(bias_plan[i]);
            sender_steady = (i == 2);
            sink_steady = (i == 2);
            if (i == 1)
            begin
                // back-to-back items against a long receiver hold
                hold_request = 1'b1;
                sender_steady = 1'b1;
                repeat (80) send_random_reading();
                sender_steady = 1'b0;
            end
            repeat (PHASE_LEN) send_random_reading();
            settle();
        end

        $display("run covered %0d items over %0d round_bias settings", items_sent,
                 bias_settings);
        $display("checked %0d results, %0d window averages, %0d flagged as failed",
                 results_seen, windows_seen, flagged_seen);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
